[design/snd_pkg.sv]
`default_nettype none

package snd_pkg;

    // buffer and message geometry
    localparam int META_LEN    = 5;
    localparam int COUNT_LIMIT = 511;
    localparam int COUNT_W     = $clog2(COUNT_LIMIT + 1);
    localparam int CAP_DEPTH   = 14;
    localparam int CAP_LO      = 2;
    localparam int HDR_LEN     = 2;
    localparam int MIN_BUFFERED = 6;

    // header and message codes
    localparam logic [7:0] BYTE_HDR0      = 8'hEF;
    localparam logic [7:0] BYTE_HDR1      = 8'hDD;
    localparam logic [7:0] TYPE_INFO      = 8'h07;
    localparam logic [7:0] TYPE_EVENT     = 8'h0C;
    localparam logic [7:0] EVT_WEIGHT     = 8'd5;
    localparam logic [7:0] EVT_WEIGHT_ALT = 8'd11;
    localparam logic [7:0] SIGN_LIMIT     = 8'd1;

    // header field positions in the capture
    localparam int POS_TYPE  = 2;
    localparam int POS_LEN   = 3;
    localparam int POS_EVENT = 4;

    // payload offsets for the two weight events
    localparam int OFF_SHORT = META_LEN;
    localparam int OFF_LONG  = META_LEN + 3;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CAP_DEPTH-1:CAP_LO][7:0] cap_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       chunk_end;
    } in_item_t;

    typedef struct packed {
        logic        responding;
        logic        weight_valid;
        logic [23:0] weight_magnitude;
        logic [7:0]  decimal_places;
        logic        weight_negative;
        logic        first_weight;
    } out_item_t;

    typedef struct packed {
        count_t total_count;
        logic   header_found;
        logic   last_was_ef;
        count_t framed_count;
        logic   responding;
        logic   weight_seen;
    } state_t;

    // saturating count step
    function automatic count_t sat_inc(input count_t v);
        count_t r;
        if (v < count_t'(COUNT_LIMIT))
        begin
            r = v + 1'b1;
        end
        else
        begin
            r = count_t'(COUNT_LIMIT);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/snd_in_if.sv]
`default_nettype none

interface snd_in_if
    import snd_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/snd_out_if.sv]
`default_nettype none

interface snd_out_if
    import snd_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/snd_eval.sv]
`default_nettype none

module snd_eval
    import snd_pkg::*;
(
    input  wire in_item_t  item,
    input  wire state_t    st,
    input  wire cap_t      cap,
    output state_t         st_next,
    output cap_t           cap_next,
    output out_item_t      res,
    output logic           res_valid
);

    count_t     tc;
    count_t     fc;
    logic       hf;
    logic       lef;
    logic       resp;
    logic       seen;
    cap_t       c;
    logic [7:0] msg_type;
    logic [7:0] msg_len;
    logic [7:0] msg_event;
    count_t     msg_end;
    logic       long_form;
    count_t     need;

    always_comb
    begin
        tc        = st.total_count;
        fc        = st.framed_count;
        hf        = st.header_found;
        lef       = st.last_was_ef;
        resp      = st.responding;
        seen      = st.weight_seen;
        c         = cap;
        res       = '0;
        res_valid = 1'b0;
        msg_type  = c[POS_TYPE];
        msg_len   = c[POS_LEN];
        msg_event = c[POS_EVENT];
        msg_end   = '0;
        long_form = 1'b0;
        need      = '0;

        if (item.mode)
        begin
            // new connection
            tc   = '0;
            fc   = '0;
            hf   = 1'b0;
            lef  = 1'b0;
            resp = 1'b0;
            seen = 1'b0;
        end
        else
        begin
            // take the byte into the buffer
            tc = sat_inc(tc);
            if (hf)
            begin
                for (int i = CAP_LO; i < CAP_DEPTH; i++)
                begin
                    if (fc == count_t'(i))
                    begin
                        c[i] = item.data_byte;
                    end
                end
                fc = sat_inc(fc);
            end
            else if (lef && (item.data_byte == BYTE_HDR1))
            begin
                hf  = 1'b1;
                lef = 1'b0;
                fc  = count_t'(HDR_LEN);
            end
            else
            begin
                lef = (item.data_byte == BYTE_HDR0);
            end

            // header fields after the new byte
            msg_type  = c[POS_TYPE];
            msg_len   = c[POS_LEN];
            msg_event = c[POS_EVENT];
            msg_end   = count_t'(META_LEN) + count_t'(msg_len);
            long_form = (msg_event == EVT_WEIGHT_ALT);
            need      = long_form ? count_t'(OFF_LONG + 6) : count_t'(OFF_SHORT + 6);

            // evaluation at notification end
            res_valid = item.chunk_end;
            if (item.chunk_end && (tc >= count_t'(MIN_BUFFERED)))
            begin
                if (!hf)
                begin
                    tc  = '0;
                    fc  = '0;
                    lef = 1'b0;
                end
                else
                begin
                    tc = fc;
                    if (fc >= count_t'(META_LEN + 1))
                    begin
                        if (msg_type != TYPE_INFO)
                        begin
                            resp = 1'b1;
                        end
                        if (fc >= msg_end)
                        begin
                            if ((msg_type == TYPE_EVENT) &&
                                ((msg_event == EVT_WEIGHT) || long_form) &&
                                (fc >= need))
                            begin
                                res.weight_valid = 1'b1;
                                res.first_weight = !seen;
                                seen             = 1'b1;
                                if (long_form)
                                begin
                                    res.weight_magnitude = {c[OFF_LONG + 2], c[OFF_LONG + 1],
                                                            c[OFF_LONG]};
                                    res.decimal_places   = c[OFF_LONG + 4];
                                    res.weight_negative  = (c[OFF_LONG + 5] > SIGN_LIMIT);
                                end
                                else
                                begin
                                    res.weight_magnitude = {c[OFF_SHORT + 2], c[OFF_SHORT + 1],
                                                            c[OFF_SHORT]};
                                    res.decimal_places   = c[OFF_SHORT + 4];
                                    res.weight_negative  = (c[OFF_SHORT + 5] > SIGN_LIMIT);
                                end
                            end
                            tc  = '0;
                            fc  = '0;
                            hf  = 1'b0;
                            lef = 1'b0;
                        end
                    end
                end
            end
        end

        res.responding       = resp;
        st_next.total_count  = tc;
        st_next.framed_count = fc;
        st_next.header_found = hf;
        st_next.last_was_ef  = lef;
        st_next.responding   = resp;
        st_next.weight_seen  = seen;
        cap_next             = c;
    end

endmodule

`default_nettype wire

[design/scale_notification_deframer_top.sv]
`default_nettype none

// Scale notification deframer. Takes one notification byte per transaction on
// item, with chunk_end on the last byte of a notification and mode high for a
// new connection. Every notification end yields exactly one transaction on
// result carrying the sticky responding flag and, when a weight message was
// completed, the decoded magnitude, decimal places and sign. Other bytes and
// new-connection transactions yield no result. A byte is registered on entry
// and evaluated from that register against the buffer state, and its result
// is registered again before it reaches result. The block takes one byte per
// clock cycle; the only stall comes from a result that has not yet been taken.

module scale_notification_deframer_top
    import snd_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    snd_in_if.sink  item,
    snd_out_if.source result
);

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    state_t    st_reg;
    state_t    st_next;
    cap_t      cap_reg;
    cap_t      cap_next;
    out_item_t res;
    logic      res_valid;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;

    // buffer evaluation for the registered byte
    snd_eval u_eval (
        .item      (s1_item_reg),
        .st        (st_reg),
        .cap       (cap_reg),
        .st_next   (st_next),
        .cap_next  (cap_next),
        .res       (res),
        .res_valid (res_valid)
    );

    // stage moves unless its result would overwrite one still waiting
    assign advance    = s1_valid_reg && (!res_valid || !out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_item_reg <= item.payload;
        end
    end

    // buffer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // captured header and payload bytes
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cap_reg <= cap_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_item_reg <= res;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

endmodule

`default_nettype wire
